// File: sv/ils_pkg.sv
package ils_pkg;

  // Default limit on figures in one literal
  localparam int unsigned ILS_MAX_FIGURES = 255;

  localparam int unsigned ValW = 63;
  localparam logic [ValW-1:0] VAL_MAX = {ValW{1'b1}};

  // Parse phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_FIG  = 2'd2;

  // Radix codes
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_BIN = 2'd2;
  localparam logic [1:0] RX_OCT = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NAN   = 3'd1;
  localparam logic [2:0] ST_OCT89 = 3'd2;
  localparam logic [2:0] ST_OVF   = 3'd3;
  localparam logic [2:0] ST_MANY  = 3'd4;

  // Character codes
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_8 = 8'h38;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_B = 8'h62;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } ils_item_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [2:0]      status;
    logic            consumed;
  } ils_result_t;

  // Figure value of a character: bit 4 set when it is 0-9, A-F or a-f
  function automatic logic [4:0] ils_fig_val(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// File: sv/ils_in_stage.sv
module ils_in_stage
  import ils_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] in_ch,
  input  logic      in_end_of_source,
  input  logic      adv,
  output logic      item_vld,
  output ils_item_t item
);

  logic      vld_r;
  ils_item_t item_r;

  // Hold the item while the core cannot advance
  assign in_stall = vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.ch  <= in_ch;
      item_r.eos <= in_end_of_source;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// File: sv/ils_core.sv
module ils_core
  import ils_pkg::*;
#(
  parameter int unsigned MAX_FIGURES = ILS_MAX_FIGURES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  ils_item_t   item,
  output logic        res_vld,
  output ils_result_t res
);

  localparam int unsigned CntW = $clog2(MAX_FIGURES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FIGURES);

  logic [1:0]      phase_r, phase_nxt;
  logic [1:0]      radix_r, radix_nxt;
  logic [ValW-1:0] acc_r, acc_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  logic [4:0]      fig;
  logic            is_dig;
  logic            fig_ok;
  logic            take;
  logic [1:0]      take_radix;
  logic [67:0]     prod;
  logic [67:0]     sum;
  logic            take_ovf;
  logic [ValW-1:0] take_acc;
  logic            emit;
  logic [2:0]      emit_st;
  logic [2:0]      finish_st;

  // Decode the character
  assign fig    = ils_fig_val(item.ch);
  assign is_dig = (item.ch >= CH_0) && (item.ch <= CH_9);

  always_comb begin
    case (radix_r)
      RX_HEX:  fig_ok = fig[4];
      RX_BIN:  fig_ok = fig[4] && (fig[3:0] <= 4'd1);
      RX_OCT:  fig_ok = fig[4] && (fig[3:0] <= 4'd7);
      default: fig_ok = fig[4] && (fig[3:0] <= 4'd9);
    endcase
  end

  // Multiply by the base with shifts, add the figure, saturate
  always_comb begin
    case (take_radix)
      RX_HEX:  prod = {1'b0, acc_r, 4'b0};
      RX_BIN:  prod = {4'b0, acc_r, 1'b0};
      RX_OCT:  prod = {2'b0, acc_r, 3'b0};
      default: prod = {2'b0, acc_r, 3'b0} + {4'b0, acc_r, 1'b0};
    endcase
  end

  assign sum      = prod + {64'b0, fig[3:0]};
  assign take_ovf = sum > {5'b0, VAL_MAX};
  assign take_acc = take_ovf ? VAL_MAX : sum[ValW-1:0];

  assign finish_st = (ovf_r || acc_r == VAL_MAX) ? ST_OVF : ST_OK;

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    radix_nxt  = radix_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    cnt_nxt    = cnt_r;
    take       = 1'b0;
    take_radix = radix_r;
    emit       = 1'b0;
    emit_st    = ST_OK;
    if (step) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (item.eos || !is_dig) begin
            emit    = 1'b1;
            emit_st = ST_NAN;
          end else if (item.ch == CH_0) begin
            phase_nxt = PH_ZERO;
          end else begin
            take       = 1'b1;
            take_radix = RX_DEC;
            radix_nxt  = RX_DEC;
            phase_nxt  = PH_FIG;
          end
        end
        PH_ZERO: begin
          if (item.eos) begin
            emit    = 1'b1;
            emit_st = finish_st;
          end else if (item.ch == CH_X || item.ch == CH_B) begin
            radix_nxt = (item.ch == CH_X) ? RX_HEX : RX_BIN;
            phase_nxt = PH_FIG;
          end else if (is_dig) begin
            if (item.ch >= CH_8) begin
              emit    = 1'b1;
              emit_st = ST_OCT89;
            end else begin
              take       = 1'b1;
              take_radix = RX_OCT;
              radix_nxt  = RX_OCT;
              phase_nxt  = PH_FIG;
            end
          end else begin
            emit    = 1'b1;
            emit_st = finish_st;
          end
        end
        default: begin
          if (cnt_r >= CntMax) begin
            emit    = 1'b1;
            emit_st = ST_MANY;
          end else if (item.eos) begin
            emit    = 1'b1;
            emit_st = finish_st;
          end else if (!fig_ok) begin
            emit = 1'b1;
            if (radix_r == RX_OCT && (item.ch == CH_8 || item.ch == CH_9)) begin
              emit_st = ST_OCT89;
            end else begin
              emit_st = finish_st;
            end
          end else begin
            take      = 1'b1;
            phase_nxt = PH_FIG;
          end
        end
      endcase
    end
    if (take) begin
      acc_nxt = take_acc;
      ovf_nxt = ovf_r | take_ovf;
      cnt_nxt = cnt_r + 1'b1;
    end
    // Clear everything once a result leaves
    if (emit) begin
      phase_nxt = PH_IDLE;
      radix_nxt = RX_DEC;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      radix_r <= RX_DEC;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Form the result
  assign res_vld      = emit;
  assign res.value    = (emit_st == ST_OK) ? acc_r : '0;
  assign res.status   = emit_st;
  assign res.consumed = 1'b0;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntMax)
    else $error("figure count above limit");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> (acc_r == '0 && cnt_r == '0 && !ovf_r && radix_r == RX_DEC))
    else $error("idle with stale state");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> acc_r == VAL_MAX)
    else $error("overflow flag without saturated value");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.status != ST_OK) |-> res.value == '0)
    else $error("error result carries a value");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> phase_r == PH_IDLE)
    else $error("no return to idle after result");
`endif

endmodule

// File: sv/ils_out_stage.sv
module ils_out_stage
  import ils_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_vld,
  input  ils_result_t     res,
  output logic            adv,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ValW-1:0] out_value,
  output logic [2:0]      out_status,
  output logic            out_char_consumed
);

  logic        vld_r;
  ils_result_t res_r;

  // Advance when the result register is empty or being drained
  assign adv = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid         = vld_r;
  assign out_value         = res_r.value;
  assign out_status        = res_r.status;
  assign out_char_consumed = res_r.consumed;

endmodule

// File: sv/integer_literal_scanner_top.sv
// Integer literal scanner.
// The input channel (in_valid / in_stall) carries one source character per
// item, in_ch, with in_end_of_source marking the end of the source. Feed the
// characters of a literal starting where a number may begin. The item that
// ends the literal (a character not valid for the base, or end of source)
// yields one result on the output channel (out_valid / out_stall): the
// value, a status (ok, not a number, octal 8/9, overflow, too many figures)
// and out_char_consumed, which is always 0, so present that character again.
// Throughput: one item per cycle, sustained, while the receiver keeps up.
// The ending item is held in the input register, the core forms the result
// from it combinationally, and the result register loads it when the output
// advances; each item needs one pass through the accumulate logic, a
// shift-and-add with saturation.
// Reset (rst_n low, synchronous) empties both registers and returns the
// scanner to idle with the value cleared. When the receiver stalls, the
// result register holds and in_stall rises once the input register is full;
// nothing is dropped.
module integer_literal_scanner_top
  import ils_pkg::*;
#(
  parameter int unsigned MAX_FIGURES = ILS_MAX_FIGURES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_ch,
  input  logic            in_end_of_source,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ValW-1:0] out_value,
  output logic [2:0]      out_status,
  output logic            out_char_consumed
);

  logic        adv;
  logic        item_vld;
  ils_item_t   item;
  logic        res_vld;
  ils_result_t res;

  ils_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_end_of_source (in_end_of_source),
    .adv              (adv),
    .item_vld         (item_vld),
    .item             (item)
  );

  ils_core #(
    .MAX_FIGURES (MAX_FIGURES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (item_vld && adv),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  ils_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_vld           (res_vld),
    .res               (res),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_status        (out_status),
    .out_char_consumed (out_char_consumed)
  );

endmodule
